FILE: design/edpd_pkg.sv
// ----------------------------------------------------------------------------
// edpd_pkg: shared types, codes and arithmetic of the palette dither
// Item kinds, register map, engine states and the per-channel error
// diffusion / clamp function used by the dither engine.
// ----------------------------------------------------------------------------
package edpd_pkg;

    localparam int EDPD_MAX_ROW_WIDTH = 4096;

    // configuration port
    localparam int                   EDPD_ADDR_W     = 3;
    localparam int                   ROW_WIDTH_W     = 13;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;
    localparam logic                 REG_ROW_WIDTH   = 1'b0;

    // item fields and table geometry
    localparam int CHAN_W       = 8;
    localparam int ERR_W        = 9;
    localparam int SLOT_W       = 15;
    localparam int PAL_AW       = 8;
    localparam int PAL_DEPTH    = 1 << PAL_AW;
    localparam int IMAP_CH_BITS = 5;
    localparam int IMAP_AW      = 3 * IMAP_CH_BITS;
    localparam int IMAP_DEPTH   = 1 << IMAP_AW;

    // Floyd-Steinberg weights in sixteenths
    localparam int                 SUM_W     = 14;
    localparam logic signed [SUM_W-1:0] W_LEFT    = 14'sd7;
    localparam logic signed [SUM_W-1:0] W_UPLEFT  = 14'sd1;
    localparam logic signed [SUM_W-1:0] W_UP      = 14'sd5;
    localparam logic signed [SUM_W-1:0] W_UPRIGHT = 14'sd3;
    localparam int                 FRAC_BITS = 4;
    localparam logic signed [SUM_W-1:0] DIV_BIAS  = 14'sd15;
    localparam int                 VAL_W     = 11;
    localparam logic signed [VAL_W-1:0] CHAN_MAX  = 11'sd255;

    typedef logic [2:0][CHAN_W-1:0] t_rgb;   // [2] red, [1] green, [0] blue
    typedef logic [2:0][ERR_W-1:0]  t_err3;  // same channel order

    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_PAL_LOAD  = 2'd1,
        KIND_IMAP_LOAD = 2'd2,
        KIND_IGNORED   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_IMAP,
        ST_PAL
    } t_state;

    // Corrected and clamped channel value for one pixel.
    function automatic logic [CHAN_W-1:0] edpd_dither(
        input logic [CHAN_W-1:0]       pix,
        input logic signed [ERR_W-1:0] left,
        input logic signed [ERR_W-1:0] upleft,
        input logic signed [ERR_W-1:0] up,
        input logic signed [ERR_W-1:0] upright
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        logic signed [VAL_W-1:0] v;
        s = W_LEFT * SUM_W'(left) + W_UPLEFT * SUM_W'(upleft)
          + W_UP * SUM_W'(up) + W_UPRIGHT * SUM_W'(upright);
        // truncate toward zero: bias negative sums before the shift
        if (s < 0) begin
            q = (s + DIV_BIAS) >>> FRAC_BITS;
        end else begin
            q = s >>> FRAC_BITS;
        end
        v = VAL_W'(q) + $signed({3'b000, pix});
        if (v < 0) begin
            return '0;
        end else if (v > CHAN_MAX) begin
            return CHAN_W'(CHAN_MAX);
        end
        return v[CHAN_W-1:0];
    endfunction

endpackage

FILE: design/edpd_ifs.sv
// ----------------------------------------------------------------------------
// edpd_ifs: valid/ready channels of the palette dither
// Input items (pixels and table loads) and result items (palette indexes).
// ----------------------------------------------------------------------------
interface edpd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] table_slot;
    logic [7:0]  table_value;
    logic        start_of_image;

    modport source (
        output valid, kind, red, green, blue, table_slot, table_value, start_of_image,
        input  ready
    );
    modport sink (
        input  valid, kind, red, green, blue, table_slot, table_value, start_of_image,
        output ready
    );
endinterface

interface edpd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] colour_index;
    logic       row_end;

    modport source (
        output valid, colour_index, row_end,
        input  ready
    );
    modport sink (
        input  valid, colour_index, row_end,
        output ready
    );
endinterface

FILE: design/edpd_regs.sv
// ----------------------------------------------------------------------------
// edpd_regs: APB register block of the palette dither
// Holds row_width and derives the row width in effect, clamped to
// 1..MAX_ROW_WIDTH.
// ----------------------------------------------------------------------------
module edpd_regs
    import edpd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = EDPD_MAX_ROW_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [EDPD_ADDR_W-1:0]                 i_paddr,
    input  logic [31:0]                            i_pwdata,
    output logic [31:0]                            o_prdata,
    output logic [$clog2(MAX_ROW_WIDTH + 1)-1:0]   o_row_eff
);

    localparam int EFF_W = $clog2(MAX_ROW_WIDTH + 1);

    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic                   word;

    assign word = i_paddr[EDPD_ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
        end else if (i_psel && i_penable && i_pwrite && word == REG_ROW_WIDTH) begin
            r_row_width <= i_pwdata[ROW_WIDTH_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (word == REG_ROW_WIDTH) begin
            o_prdata = 32'(r_row_width);
        end
    end

    always_comb begin
        if (r_row_width == '0) begin
            o_row_eff = EFF_W'(1);
        end else if (32'(r_row_width) > 32'(MAX_ROW_WIDTH)) begin
            o_row_eff = EFF_W'(MAX_ROW_WIDTH);
        end else begin
            o_row_eff = EFF_W'(r_row_width);
        end
    end

endmodule

FILE: design/error_diffusion_palette_dither.sv
// ----------------------------------------------------------------------------
// error_diffusion_palette_dither: Floyd-Steinberg dither to a loaded palette
// Diffuses quantization error over raster-order RGB pixels, maps the
// corrected colour through an inverse colour map and keeps per-column error
// of the previous row in a row error memory.
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  i_item     in   valid/ready        kind, red, green, blue, table_slot,
//                                     table_value, start_of_image
//  o_result   out  valid/ready        colour_index, row_end
//  APB        in   psel/penable       paddr, pwdata, prdata (row_width at 0)
//
//  A pixel goes through launch and row error read, sum and inverse map
//  read, palette read and error update. The left error loop runs through
//  both table reads. Table loads and ignored items are taken in the idle state.
//  An input buffer takes the next transaction while a pixel is in flight;
//  a result register holds a stalled result and stalls only the last stage.
//  Reset takes effect at once; row error entries never written read as zero
//  through a fill count, so there is no clearing pass.
// ----------------------------------------------------------------------------
module error_diffusion_palette_dither
    import edpd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = EDPD_MAX_ROW_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    edpd_item_if.sink              i_item,
    edpd_result_if.source          o_result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [EDPD_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int EFF_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int ENT_W = COL_W + 1;

    t_state r_state, n_state;
    logic   take, launch, in_sum, in_imap, finish;

    // input buffer
    logic              r_in_valid;
    t_kind             r_in_kind;
    t_rgb              r_in_pix;
    logic [SLOT_W-1:0] r_in_slot;
    logic [7:0]        r_in_tval;
    logic              r_in_sof;

    // row state
    logic [EFF_W-1:0] row_eff;
    logic [COL_W-1:0] r_column;
    logic             r_first;
    t_err3            r_left;
    logic [EFF_W-1:0] r_hw;
    t_rgb             r_pix;
    t_err3            r_prev_up;

    // memories and their read data
    t_err3       r_row_err [MAX_ROW_WIDTH];
    t_err3       r_up_q, r_ur_q;
    logic        r_up_ok, r_ur_ok;
    logic [7:0]  r_inv_map [IMAP_DEPTH];
    logic [7:0]  r_imap_q;
    t_rgb        r_palette [PAL_DEPTH];
    t_rgb        r_pal_q;

    t_rgb               r_val, sum_val;
    logic [IMAP_AW-1:0] imap_addr;
    logic [7:0]         r_colour;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_colour;
    logic       r_out_row_end;

    logic [COL_W-1:0] col_l;
    logic [ENT_W-1:0] e_up_l, e_ur_l, e_cur, e_up, e_ur, eff_e;
    t_err3            raw_up, raw_ur, ul_use, up_use, ur_use, n_err;
    logic             last, pal_we, imap_we;

    edpd_regs #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_row_eff (row_eff)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        take    = 1'b0;
        launch  = 1'b0;
        in_sum  = 1'b0;
        in_imap = 1'b0;
        finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_in_valid) begin
                    take = 1'b1;
                    if (r_in_kind == KIND_PIXEL) begin
                        launch  = 1'b1;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                in_sum  = 1'b1;
                n_state = ST_IMAP;
            end
            ST_IMAP: begin
                in_imap = 1'b1;
                n_state = ST_PAL;
            end
            ST_PAL: begin
                // hold the finished pixel until the result register frees up
                if (!r_out_valid || o_result.ready) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    assign i_item.ready = !r_in_valid || take;
    assign pal_we  = take && r_in_kind == KIND_PAL_LOAD && r_in_slot[SLOT_W-1:PAL_AW] == '0;
    assign imap_we = take && r_in_kind == KIND_IMAP_LOAD;

    // ------------------------------------------------------------------
    // row error addressing
    // ------------------------------------------------------------------
    assign col_l  = r_in_sof ? '0 : r_column;
    assign e_up_l = ENT_W'(col_l) + ENT_W'(1);
    assign e_ur_l = ENT_W'(col_l) + ENT_W'(2);
    assign e_cur  = ENT_W'(r_column);
    assign e_up   = e_cur + ENT_W'(1);
    assign e_ur   = e_cur + ENT_W'(2);
    assign eff_e  = ENT_W'(row_eff);
    assign last   = e_up >= eff_e;

    // entries past the fill count were never written and read as zero
    assign raw_up = r_up_ok ? r_up_q : '0;
    assign raw_ur = r_ur_ok ? r_ur_q : '0;
    assign ul_use = (!r_first && r_column != '0 && e_cur < eff_e) ? r_prev_up : '0;
    assign up_use = (!r_first && e_up < eff_e) ? raw_up : '0;
    assign ur_use = (!r_first && e_ur < eff_e) ? raw_ur : '0;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_val[ch] = edpd_dither(r_pix[ch], r_left[ch], ul_use[ch],
                                      up_use[ch], ur_use[ch]);
            n_err[ch]   = {1'b0, r_val[ch]} - {1'b0, r_pal_q[ch]};
        end
    end

    assign imap_addr = {sum_val[2][CHAN_W-1 -: IMAP_CH_BITS],
                        sum_val[1][CHAN_W-1 -: IMAP_CH_BITS],
                        sum_val[0][CHAN_W-1 -: IMAP_CH_BITS]};

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_column    <= '0;
            r_first     <= 1'b1;
            r_left      <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (launch && r_in_sof) begin
                r_column <= '0;
                r_first  <= 1'b1;
                r_left   <= '0;
            end else if (finish) begin
                if (last) begin
                    r_column <= '0;
                    r_first  <= 1'b0;
                    r_left   <= '0;
                end else begin
                    r_column <= COL_W'(e_up);
                    r_left   <= n_err;
                end
            end
            // advance the fill count as the write front moves right
            if (in_sum && e_up > ENT_W'(r_hw)) begin
                r_hw <= EFF_W'(e_up);
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind <= t_kind'(i_item.kind);
            r_in_pix  <= {i_item.red, i_item.green, i_item.blue};
            r_in_slot <= i_item.table_slot;
            r_in_tval <= i_item.table_value;
            r_in_sof  <= i_item.start_of_image;
        end
        if (launch) begin
            r_pix   <= r_in_pix;
            r_up_ok <= e_up_l < ENT_W'(r_hw);
            r_ur_ok <= e_ur_l < ENT_W'(r_hw);
        end
        if (in_sum) begin
            r_val     <= sum_val;
            r_prev_up <= raw_up;
        end
        if (in_imap) begin
            r_colour <= r_imap_q;
        end
        if (finish) begin
            r_out_colour  <= r_colour;
            r_out_row_end <= last;
        end
    end

    // ------------------------------------------------------------------
    // memories: the write at this column lands in the cycle after the
    // launch reads, and within a row the next launch reads only columns
    // to the right
    always_ff @(posedge i_clk) begin
        if (in_sum) begin
            r_row_err[r_column] <= r_left;
        end
        if (launch) begin
            r_up_q <= r_row_err[e_up_l[COL_W-1:0]];
            r_ur_q <= r_row_err[e_ur_l[COL_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (imap_we) begin
            r_inv_map[r_in_slot] <= r_in_tval;
        end
        if (in_sum) begin
            r_imap_q <= r_inv_map[imap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[r_in_slot[PAL_AW-1:0]] <= r_in_pix;
        end
        if (in_imap) begin
            r_pal_q <= r_palette[r_imap_q];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.colour_index = r_out_colour;
    assign o_result.row_end      = r_out_row_end;

endmodule

FILE: design/edpd_check.sv
// ----------------------------------------------------------------------------
// edpd_check: port-level checks of the palette dither
// Watches the result channel and the register port of the top level.
// ----------------------------------------------------------------------------
module edpd_check
    import edpd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [7:0]             i_out_colour,
    input logic                   i_out_row_end,
    input logic                   i_psel,
    input logic                   i_penable,
    input logic                   i_pwrite,
    input logic [EDPD_ADDR_W-1:0] i_paddr,
    input logic [31:0]            i_pwdata,
    input logic [31:0]            i_prdata
);

    logic [ROW_WIDTH_W-1:0] r_width;
    logic                   word;

    assign word = i_paddr[EDPD_ADDR_W-1];

    // track the programmed row width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= ROW_WIDTH_RESET;
        end else if (i_psel && i_penable && i_pwrite && word == REG_ROW_WIDTH) begin
            r_width <= i_pwdata[ROW_WIDTH_W-1:0];
        end
    end

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_colour) && $stable(i_out_row_end))
        else $error("stalled result changed");

    a_single_pixel_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_width <= ROW_WIDTH_W'(1) |-> i_out_row_end)
        else $error("row of one pixel without row end");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && !i_pwrite && word == REG_ROW_WIDTH |->
            i_prdata == 32'(r_width))
        else $error("row width readback mismatch");

endmodule

bind error_diffusion_palette_dither edpd_check u_edpd_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_colour  (o_result.colour_index),
    .i_out_row_end (o_result.row_end),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_paddr       (paddr),
    .i_pwdata      (pwdata),
    .i_prdata      (prdata)
);

FILE: verif/edpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpd_checker: result checker of the palette dither
// Watches the item, result and register channels, runs its own error
// diffusion prediction for every accepted pixel and compares each accepted
// result, field by field, with the oldest predicted palette index.
// ----------------------------------------------------------------------------
module edpd_checker
    import edpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    edpd_item_if                   i_item,
    edpd_result_if                 i_result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [EDPD_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    input  logic [31:0]            prdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results
);

    localparam logic [EDPD_ADDR_W-1:0] ROW_WIDTH_ADDR = EDPD_ADDR_W'(4 * int'(REG_ROW_WIDTH));

    typedef logic signed [ERR_W-1:0] t_serr;

    typedef struct packed {
        logic [CHAN_W-1:0] colour_index;
        logic              row_end;
    } t_index_out;

    logic [CHAN_W-1:0]      inv_map   [IMAP_DEPTH];
    t_rgb                   palette   [PAL_DEPTH];
    t_serr                  above_err [EDPD_MAX_ROW_WIDTH][3];
    t_serr                  left_err  [3];
    int unsigned            column;
    bit                     top_row;
    logic [ROW_WIDTH_W-1:0] row_width;
    t_index_out             index_queue [$];
    int                     mismatch_count;
    int                     results_seen;

    function automatic int unsigned active_width();
        int unsigned w = row_width;
        if (w < 1) begin
            w = 1;
        end
        if (w > EDPD_MAX_ROW_WIDTH) begin
            w = EDPD_MAX_ROW_WIDTH;
        end
        return w;
    endfunction

    // previous-row error; first row and columns past the row end give zero
    function automatic int upper_err(int unsigned entry, int unsigned width, int ch);
        if (top_row || entry >= width) begin
            return 0;
        end
        return int'(above_err[entry][ch]);
    endfunction

    function automatic void dither_pixel(input t_rgb rgb, input logic sof);
        int unsigned        width;
        int                 total;
        int                 level;
        t_rgb               clamped;
        logic [IMAP_AW-1:0] map_addr;
        logic [CHAN_W-1:0]  index;
        t_rgb               entry;
        bit                 last_in_row;
        if (sof) begin
            column  = 0;
            top_row = 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
                left_err[ch] = '0;
            end
        end
        width = active_width();
        for (int ch = 0; ch < 3; ch++) begin
            total = 7 * int'(left_err[ch]) + upper_err(column, width, ch)
                  + 5 * upper_err(column + 1, width, ch) + 3 * upper_err(column + 2, width, ch);
            level = int'(rgb[ch]) + total / 16;
            if (level > 255) begin
                level = 255;
            end else if (level < 0) begin
                level = 0;
            end
            clamped[ch] = CHAN_W'(level);
            if (column < EDPD_MAX_ROW_WIDTH) begin
                above_err[column][ch] = left_err[ch];
            end
        end
        map_addr = {clamped[2][7:3], clamped[1][7:3], clamped[0][7:3]};
        index    = inv_map[map_addr];
        entry    = palette[index];
        for (int ch = 0; ch < 3; ch++) begin
            left_err[ch] = t_serr'(int'(clamped[ch]) - int'(entry[ch]));
        end
        last_in_row = (column + 1 >= width);
        if (last_in_row) begin
            column  = 0;
            top_row = 1'b0;
            for (int ch = 0; ch < 3; ch++) begin
                left_err[ch] = '0;
            end
        end else begin
            column++;
        end
        index_queue.push_back('{colour_index: index, row_end: last_in_row});
    endfunction

    task automatic report(input string what);
        if (mismatch_count < 20) begin
            $display("%0t ns  mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_index_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < EDPD_MAX_ROW_WIDTH; i++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    above_err[i][ch] = '0;
                end
            end
            for (int ch = 0; ch < 3; ch++) begin
                left_err[ch] = '0;
            end
            for (int i = 0; i < IMAP_DEPTH; i++) begin
                inv_map[i] = '0;
            end
            for (int i = 0; i < PAL_DEPTH; i++) begin
                palette[i] = '0;
            end
            column    = 0;
            top_row   = 1'b1;
            row_width = ROW_WIDTH_RESET;
            index_queue.delete();
        end else begin
            // results leave before this edge's item can have produced one
            if (i_result.valid && i_result.ready) begin
                results_seen++;
                if (index_queue.size() == 0) begin
                    report($sformatf("result index %0d row_end %0b with no pixel pending",
                                     i_result.colour_index, i_result.row_end));
                end else begin
                    want = index_queue.pop_front();
                    if (i_result.colour_index !== want.colour_index) begin
                        report($sformatf("result %0d colour_index %0d, predicted %0d",
                                         results_seen, i_result.colour_index,
                                         want.colour_index));
                    end
                    if (i_result.row_end !== want.row_end) begin
                        report($sformatf("result %0d row_end %0b, predicted %0b",
                                         results_seen, i_result.row_end, want.row_end));
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                case (t_kind'(i_item.kind))
                    KIND_PIXEL: begin
                        dither_pixel({i_item.red, i_item.green, i_item.blue},
                                     i_item.start_of_image);
                    end
                    KIND_PAL_LOAD: begin
                        if (i_item.table_slot < PAL_DEPTH) begin
                            palette[i_item.table_slot[PAL_AW-1:0]] =
                                {i_item.red, i_item.green, i_item.blue};
                        end
                    end
                    KIND_IMAP_LOAD: begin
                        inv_map[i_item.table_slot] = i_item.table_value;
                    end
                    default: begin
                    end
                endcase
            end
            if (psel && penable && pready && paddr == ROW_WIDTH_ADDR) begin
                if (pwrite) begin
                    row_width = pwdata[ROW_WIDTH_W-1:0];
                end else if (prdata[ROW_WIDTH_W-1:0] !== row_width) begin
                    report($sformatf("row_width reads back %0d, last written %0d",
                                     prdata[ROW_WIDTH_W-1:0], row_width));
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= index_queue.size();
        o_results    <= results_seen;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the error diffusion palette dither
// Loads a full colour cube palette and inverse map, runs directed pixels over
// the row edges and width extremes, then random images with table reloads,
// width changes and bursty traffic under back-pressure, all checked by
// edpd_checker.
// ----------------------------------------------------------------------------
module tb;
    import edpd_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int PIXEL_TARGET = 650;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;
    localparam logic [EDPD_ADDR_W-1:0] ROW_WIDTH_ADDR = EDPD_ADDR_W'(4 * int'(REG_ROW_WIDTH));

    typedef struct packed {
        t_kind             kind;
        t_rgb              rgb;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] value;
        logic              sof;
    } t_item;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic                   pready;
    logic [EDPD_ADDR_W-1:0] paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    int                     fail_count;
    int                     pending;
    int                     results;
    int                     burst_left;
    int                     hold_req;
    int                     hold_done;
    int                     pixels_sent;
    int                     loads_sent;
    int                     widths_used;

    edpd_item_if   item_ch();
    edpd_result_if result_ch();

    error_diffusion_palette_dither u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    edpd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_item make_item(t_kind kind, t_rgb rgb, logic [SLOT_W-1:0] slot,
                                        logic [CHAN_W-1:0] value, logic sof);
        t_item it;
        it.kind  = kind;
        it.rgb   = rgb;
        it.slot  = slot;
        it.value = value;
        it.sof   = sof;
        return it;
    endfunction

    // pixel with don't-care table fields
    function automatic t_item pixel(t_rgb rgb, logic sof);
        return make_item(KIND_PIXEL, rgb, SLOT_W'($urandom), CHAN_W'($urandom), sof);
    endfunction

    // offer one transaction; called at a rising edge, returns at the accepting edge
    task automatic send_item(input t_item it);
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        item_ch.valid          <= 1'b1;
        item_ch.kind           <= it.kind;
        item_ch.red            <= it.rgb[2];
        item_ch.green          <= it.rgb[1];
        item_ch.blue           <= it.rgb[0];
        item_ch.table_slot     <= it.slot;
        item_ch.table_value    <= it.value;
        item_ch.start_of_image <= it.sof;
        do @(posedge i_clk); while (!item_ch.ready);
        if (it.kind == KIND_PIXEL) begin
            pixels_sent++;
        end else begin
            loads_sent++;
        end
    endtask

    // hold the sender until every predicted index has come back, then let loads settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write row_width, then read it back in the next transfer
    task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROW_WIDTH_ADDR;
        pwdata  <= 32'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        widths_used++;
    endtask

    initial begin
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge i_clk);
        end
        $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall levels in stretches, long hold-offs on request
    initial begin
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch   = 0;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stretch--;
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        int                     phase;
        int                     count;
        int                     pick;
        logic [ROW_WIDTH_W-1:0] width;
        bit                     new_image;
        t_rgb                   rgb;

        burst_left  = 0;
        hold_req    = 0;
        hold_done   = 0;
        pixels_sent = 0;
        loads_sent  = 0;
        widths_used = 0;
        item_ch.valid          <= 1'b0;
        item_ch.kind           <= KIND_PIXEL;
        item_ch.red            <= '0;
        item_ch.green          <= '0;
        item_ch.blue           <= '0;
        item_ch.table_slot     <= '0;
        item_ch.table_value    <= '0;
        item_ch.start_of_image <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3-3-2 colour cube palette and a matching inverse map, every entry written
        for (int i = 0; i < PAL_DEPTH; i++) begin
            send_item(make_item(KIND_PAL_LOAD,
                                {8'((i >> 5) * 255 / 7), 8'(((i >> 2) & 7) * 255 / 7),
                                 8'((i & 3) * 85)},
                                SLOT_W'(i), CHAN_W'($urandom), 1'($urandom)));
        end
        for (int a = 0; a < IMAP_DEPTH; a++) begin
            send_item(make_item(KIND_IMAP_LOAD, t_rgb'($urandom), SLOT_W'(a),
                                {a[14:12], a[9:7], a[4:3]}, 1'($urandom)));
        end

        // reset width: extremes, an ignored kind and an out-of-range palette slot
        send_item(pixel(24'h000000, 1'b1));
        send_item(pixel(24'hffffff, 1'b0));
        send_item(pixel({8'd128, 8'd64, 8'd200}, 1'b0));
        send_item(make_item(KIND_IGNORED, 24'hffffff, 15'h7fff, 8'hff, 1'b1));
        send_item(make_item(KIND_PAL_LOAD, 24'h123456, 15'd300, 8'h00, 1'b1));
        send_item(pixel(24'hff00ff, 1'b0));
        drain();

        // three-pixel rows: row ends, upper-row errors, palette change and restart mid-row
        set_row_width(13'd3);
        send_item(pixel(24'h0f0f0f, 1'b1));
        send_item(pixel(24'hff8000, 1'b0));
        send_item(pixel(24'h00ff7f, 1'b0));
        send_item(pixel(24'h808080, 1'b0));
        send_item(make_item(KIND_PAL_LOAD, 24'h00ff00, 15'd255, 8'h00, 1'b0));
        send_item(pixel(24'hffffff, 1'b0));
        send_item(pixel(24'h000000, 1'b0));
        send_item(pixel(24'h7f7f7f, 1'b0));
        send_item(pixel(24'h404040, 1'b1));
        send_item(pixel(24'h202020, 1'b0));
        send_item(pixel(24'hc0c0c0, 1'b0));
        drain();

        // zero width acts as one pixel per row
        set_row_width(13'd0);
        send_item(pixel(24'hfefefe, 1'b0));
        send_item(pixel(24'h010101, 1'b0));
        send_item(pixel(24'hff0000, 1'b0));
        drain();

        // widest register value clips to the maximum row
        set_row_width(13'h1fff);
        send_item(pixel(24'h0000ff, 1'b1));
        send_item(pixel(24'h00ff00, 1'b0));
        send_item(pixel(24'hffff00, 1'b0));
        send_item(pixel(24'h55aa55, 1'b0));
        drain();

        phase = 0;
        while (pixels_sent < PIXEL_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                width = $urandom_range(1, 8);
            end else if (pick < 80) begin
                width = $urandom_range(9, 40);
            end else if (pick < 88) begin
                width = $urandom_range(41, 700);
            end else if (pick < 94) begin
                width = pick[0] ? 13'd4096 : 13'd1;
            end else begin
                width = pick[0] ? 13'd0 : ROW_WIDTH_W'($urandom_range(4097, 8191));
            end
            set_row_width(width);
            // sometimes keep the image going across a width change
            new_image = (phase == 0) || ($urandom_range(0, 9) < 7);
            count = $urandom_range(8, 40);
            if (phase % 8 == 2) begin
                count = 60;
                hold_req++;
            end
            for (int k = 0; k < count; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    send_item(make_item(KIND_PAL_LOAD, t_rgb'($urandom),
                                        ($urandom_range(0, 9) == 0)
                                            ? SLOT_W'($urandom_range(256, 32767))
                                            : SLOT_W'($urandom_range(0, 255)),
                                        CHAN_W'($urandom), 1'($urandom)));
                end else if (pick < 12) begin
                    send_item(make_item(KIND_IMAP_LOAD, t_rgb'($urandom), SLOT_W'($urandom),
                                        CHAN_W'($urandom), 1'($urandom)));
                end else if (pick < 14) begin
                    send_item(make_item(KIND_IGNORED, t_rgb'($urandom), SLOT_W'($urandom),
                                        CHAN_W'($urandom), 1'($urandom)));
                end else begin
                    rgb = t_rgb'($urandom);
                    if ($urandom_range(0, 4) == 0) begin
                        // saturated channels drive the clamp
                        rgb = {{8{rgb[2][0]}}, {8{rgb[1][0]}}, {8{rgb[0][0]}}};
                    end
                    send_item(pixel(rgb, (k == 0 && new_image) || $urandom_range(0, 49) == 0));
                end
            end
            drain();
            phase++;
        end

        $display("Covered %0d pixels and %0d load/ignored items over %0d row width settings,",
                 pixels_sent, loads_sent, widths_used);
        $display("  %0d palette indexes checked, %0d long output hold-offs of %0d cycles.",
                 results, hold_done, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
